[src/lrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared sizes, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int FB_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int DW   = 13;  // image sizes, up to 4096
  localparam int FRAC = 12;  // fraction bits of scaled points
  localparam int PW   = 28;  // scaled point
  localparam int DXW  = 29;  // endpoint difference
  localparam int SQW  = 58;  // squared length
  localparam int NW   = 29;  // divisor and remainders
  localparam int CW   = 17;  // point counts
  localparam int FW   = 20;  // walk quotients

  localparam int QDEPTH = 2;

  localparam logic [23:0] PIX_WHITE = 24'hFFFFFF;
  localparam logic [23:0] PIX_BLACK = 24'h000000;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_SCALE  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]           req;
    logic [23:0]          colour;
    logic [7:0]           pix_x;
    logic [7:0]           pix_y;
    logic [CW-1:0]        d;
    logic [NW-1:0]        den;
    logic signed [FW-1:0] fx;
    logic [NW-1:0]        rx;
    logic signed [FW-1:0] qx;
    logic [NW-1:0]        sx;
    logic signed [FW-1:0] fy;
    logic [NW-1:0]        ry;
    logic signed [FW-1:0] qy;
    logic [NW-1:0]        sy;
  } cmd_t;

endpackage
`default_nettype wire

[src/lrf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_req_if / lrf_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface lrf_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [23:0]        colour;
  logic [7:0]         pixel_x;
  logic [7:0]         pixel_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, colour,
                  pixel_x, pixel_y, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, colour,
                pixel_x, pixel_y, output ready);
endinterface

interface lrf_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] read_colour;
  logic [16:0] pixels_written;
  logic [16:0] pixels_skipped;
  logic        read_out_of_range;

  modport source (output valid, read_colour, pixels_written, pixels_skipped,
                  read_out_of_range, input ready);
  modport sink (input valid, read_colour, pixels_written, pixels_skipped,
                read_out_of_range, output ready);
endinterface
`default_nettype wire

[src/line_raster_framebuffer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// line_raster_framebuffer_top
// 256x256 24-bit framebuffer with clear, draw-line and read-pixel commands.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  req      in   valid/ready      req_type, endpoints, colour, pixel address
//  res      out  valid/ready      read_colour, counts, read_out_of_range
//  cfg      in   cfg_we           cfg_index, cfg_data (scale, width, height)
//
//  Work (accept to result, idle block): a clear sweeps width*height pixels;
//  a read waits on the registered RAM read; a line is set up in the front
//  (29-step square root, two 29-step divides), then walked in the back
//  from the queue pop, d+1 points on the one framebuffer write port.
//  Setup of the next line overlaps the current walk.
//  Reset: a sweep over all 65536 pixels writes the reset image; no word is
//  taken meanwhile, config writes are.
//  Stalls: a two-entry queue parts front and back; the result register holds
//  one word while the back waits for it to be taken.
// ----------------------------------------------------------------------------
module line_raster_framebuffer_top import lrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  lrf_req_if.sink          req,
  lrf_res_if.source        res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  // config registers
  logic [11:0] scale;
  logic [8:0]  image_width;
  logic [8:0]  image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= 12'd256;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:  scale        <= cfg_data;
        CFG_WIDTH:  image_width  <= cfg_data[8:0];
        CFG_HEIGHT: image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  cmd_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;
  logic init_busy;

  // front: classify, scale, length and step setup
  lrf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .scale  (scale),
    .hold   (init_busy),
    .q_data (q_wdata),
    .q_push (q_push),
    .q_full (q_full)
  );

  lrf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: framebuffer owner
  lrf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .image_width  (image_width),
    .image_height (image_height),
    .res          (res),
    .init_busy    (init_busy)
  );

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !res.valid)
    else $error("result word during reset sweep");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue pushed while full");

endmodule
`default_nettype wire

[src/lrf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module lrf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/lrf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module lrf_queue import lrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);

  localparam int PTW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CTW = $clog2(QDEPTH + 1);

  cmd_t           slot [QDEPTH];
  logic [PTW-1:0] wp;
  logic [PTW-1:0] rp;
  logic [CTW-1:0] count;

  assign full  = (count == CTW'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= wdata;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/lrf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_front
// Takes request words; for lines scales endpoints, takes the integer length
// by an iterative square root and splits the step by an iterative divider.
// ----------------------------------------------------------------------------
module lrf_front import lrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  lrf_req_if.sink          req,
  input  wire logic [11:0] scale,
  input  wire logic        hold,
  output cmd_t             q_data,
  output logic             q_push,
  input  wire logic        q_full
);

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_DIFF, F_SQ, F_SUM, F_SQRT, F_DEN,
    F_DIVX, F_FINX, F_DIVY, F_FINY, F_PUSH
  } fstate_t;

  typedef struct packed {
    logic signed [FW-1:0] q;
    logic [NW-1:0]        r;
  } divres_t;

  fstate_t              state;
  cmd_t                 cmd;
  logic signed [15:0]   vx0, vy0, vx1, vy1;
  logic signed [PW-1:0] p0x, p0y, p1x, p1y;
  logic signed [DXW-1:0] dx, dy;
  logic [SQW-1:0]       sqx, sqy, s, r, b;
  logic [4:0]           cnt;
  logic [DXW-1:0]       dnum;
  logic [NW-1:0]        drem;

  logic [DXW-1:0] adx, ady;
  logic [SQW-1:0] rb;
  logic [CW-1:0]  dd;
  logic [NW:0]    t;
  logic           t_ge;
  divres_t        fin_x, fin_y;

  // floor quotient and nonnegative remainder from magnitude results
  function automatic divres_t fix_sign(input logic neg, input logic [DXW-1:0] q,
                                       input logic [NW-1:0] rem,
                                       input logic [NW-1:0] den);
    divres_t o;
    logic [FW-1:0] qs;
    qs = q[FW-1:0];
    if (neg && rem != '0) begin
      o.q = $signed(~qs);
      o.r = den - rem;
    end else if (neg) begin
      o.q = $signed(~qs + 1'b1);
      o.r = '0;
    end else begin
      o.q = $signed(qs);
      o.r = rem;
    end
    return o;
  endfunction

  assign adx  = dx[DXW-1] ? (~dx + 1'b1) : dx;
  assign ady  = dy[DXW-1] ? (~dy + 1'b1) : dy;
  assign rb   = r + b;
  assign dd   = (r[NW-1:FRAC] == '0) ? CW'(1) : r[NW-1:FRAC];
  assign t    = {drem, dnum[DXW-1]};
  assign t_ge = (t >= {1'b0, cmd.den});
  assign fin_x = fix_sign(dx[DXW-1], dnum, drem, cmd.den);
  assign fin_y = fix_sign(dy[DXW-1], dnum, drem, cmd.den);

  assign req.ready = (state == F_IDLE) && !hold;
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_data    = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.valid && !hold) begin
            cmd        <= '0;
            cmd.req    <= req.req_type;
            cmd.colour <= req.colour;
            cmd.pix_x  <= req.pixel_x;
            cmd.pix_y  <= req.pixel_y;
            vx0 <= req.start_x;
            vy0 <= req.start_y;
            vx1 <= req.end_x;
            vy1 <= req.end_y;
            state <= (req.req_type == REQ_LINE) ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          p0x <= PW'(vx0 * $signed({1'b0, scale}));
          p0y <= PW'(vy0 * $signed({1'b0, scale}));
          p1x <= PW'(vx1 * $signed({1'b0, scale}));
          p1y <= PW'(vy1 * $signed({1'b0, scale}));
          state <= F_DIFF;
        end
        F_DIFF: begin
          dx <= DXW'(p0x) - DXW'(p1x);
          dy <= DXW'(p0y) - DXW'(p1y);
          state <= F_SQ;
        end
        F_SQ: begin
          sqx <= {{(SQW-DXW){1'b0}}, adx} * {{(SQW-DXW){1'b0}}, adx};
          sqy <= {{(SQW-DXW){1'b0}}, ady} * {{(SQW-DXW){1'b0}}, ady};
          state <= F_SUM;
        end
        F_SUM: begin
          s   <= sqx + sqy;
          r   <= '0;
          b   <= SQW'(1) << (SQW - 2);
          cnt <= 5'(SQW / 2 - 1);
          state <= F_SQRT;
        end
        F_SQRT: begin
          if (s >= rb) begin
            s <= s - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b   <= b >> 2;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= F_DEN;
          end
        end
        F_DEN: begin
          cmd.d   <= r[NW-1:FRAC];
          cmd.den <= {dd, {FRAC{1'b0}}};
          cmd.fx  <= FW'(p1x >>> FRAC);
          cmd.fy  <= FW'(p1y >>> FRAC);
          cmd.rx  <= NW'(p1x[FRAC-1:0] * dd);
          cmd.ry  <= NW'(p1y[FRAC-1:0] * dd);
          dnum    <= adx;
          drem    <= '0;
          cnt     <= 5'(DXW - 1);
          state   <= F_DIVX;
        end
        F_DIVX, F_DIVY: begin
          if (t_ge) begin
            drem <= NW'(t - {1'b0, cmd.den});
          end else begin
            drem <= t[NW-1:0];
          end
          dnum <= {dnum[DXW-2:0], t_ge};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= (state == F_DIVX) ? F_FINX : F_FINY;
          end
        end
        F_FINX: begin
          cmd.qx <= fin_x.q;
          cmd.sx <= fin_x.r;
          dnum   <= ady;
          drem   <= '0;
          cnt    <= 5'(DXW - 1);
          state  <= F_DIVY;
        end
        F_FINY: begin
          cmd.qy <= fin_y.q;
          cmd.sy <= fin_y.r;
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/lrf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_back
// Runs commands against the framebuffer: clear sweep, line walk, pixel read.
// Also sweeps the reset image into the framebuffer after reset.
// ----------------------------------------------------------------------------
module lrf_back import lrf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       q_data,
  input  wire logic       q_empty,
  output logic            q_pop,
  input  wire logic [8:0] image_width,
  input  wire logic [8:0] image_height,
  lrf_res_if.source       res,
  output logic            init_busy
);

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_CLR, B_LINE, B_LEND, B_LOUT, B_RDW
  } bstate_t;

  typedef struct packed {
    logic signed [FW-1:0] f;
    logic [NW-1:0]        r;
  } walk_t;

  bstate_t              state;
  logic [XW-1:0]        cx;
  logic [YW-1:0]        cy;
  logic [DW-1:0]        cw, ch;
  cmd_t                 cur;
  logic signed [FW-1:0] fx, fy;
  logic [NW-1:0]        rx, ry;
  logic [CW-1:0]        k;
  logic                 pt_v;
  logic signed [FW-1:0] ptx, pty;
  logic [CW-1:0]        written, skipped;

  logic [DW-1:0] eff_w, eff_h;
  logic          sweep_last, in_img, rd_oor;
  walk_t         nx, ny;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;

  function automatic logic signed [FW-1:0] rnd(input logic signed [FW-1:0] f,
                                               input logic [NW-1:0] r,
                                               input logic [NW-1:0] den);
    logic [NW-1:0] half;
    logic          up;
    half = den >> 1;
    up   = f[FW-1] ? (r > half) : (r >= half);
    return f + $signed({{(FW-1){1'b0}}, up});
  endfunction

  function automatic walk_t step(input logic signed [FW-1:0] f, input logic [NW-1:0] r,
                                 input logic signed [FW-1:0] q, input logic [NW-1:0] s,
                                 input logic [NW-1:0] den);
    walk_t      o;
    logic [NW:0] sum;
    sum = {1'b0, r} + {1'b0, s};
    if (sum >= {1'b0, den}) begin
      o.r = NW'(sum - {1'b0, den});
      o.f = f + q + $signed(FW'(1));
    end else begin
      o.r = sum[NW-1:0];
      o.f = f + q;
    end
    return o;
  endfunction

  assign eff_w = (DW'(image_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(image_width);
  assign eff_h = (DW'(image_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT)
                                                       : DW'(image_height);
  assign sweep_last = (DW'(cx) == cw - 1'b1) && (DW'(cy) == ch - 1'b1);
  assign rd_oor = (DW'(q_data.pix_x) >= eff_w) || (DW'(q_data.pix_y) >= eff_h);
  assign in_img = !ptx[FW-1] && (ptx < $signed({{(FW-DW){1'b0}}, cw}))
               && !pty[FW-1] && (pty < $signed({{(FW-DW){1'b0}}, ch}));
  assign nx = step(fx, rx, cur.qx, cur.sx, cur.den);
  assign ny = step(fy, ry, cur.qy, cur.sy, cur.den);

  assign q_pop     = (state == B_IDLE) && !q_empty && (!res.valid || res.ready);
  assign init_busy = (state == B_INIT);

  always_comb begin
    if (state == B_INIT || state == B_CLR) begin
      we    = 1'b1;
      waddr = {cy, cx};
      wdata = (cy == '0 || DW'(cy) == ch - 1'b1) ? PIX_BLACK : PIX_WHITE;
    end else begin
      we    = pt_v && in_img;
      waddr = {pty[YW-1:0], ptx[XW-1:0]};
      wdata = cur.colour;
    end
  end

  assign raddr = {YW'(q_data.pix_y), XW'(q_data.pix_x)};

  lrf_ram #(.WIDTH(24), .DEPTH(FB_DEPTH)) u_fb (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (pt_v) begin
      if (in_img) begin
        written <= written + 1'b1;
      end else begin
        skipped <= skipped + 1'b1;
      end
    end
    if (rst) begin
      state     <= B_INIT;
      cx        <= '0;
      cy        <= '0;
      cw        <= DW'(MAX_WIDTH);
      ch        <= DW'(MAX_HEIGHT);
      pt_v      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      pt_v <= (state == B_LINE);
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        B_INIT, B_CLR: begin
          if (sweep_last) begin
            if (state == B_CLR) begin
              res.valid             <= 1'b1;
              res.read_colour       <= '0;
              res.pixels_written    <= '0;
              res.pixels_skipped    <= '0;
              res.read_out_of_range <= 1'b0;
            end
            state <= B_IDLE;
          end else if (DW'(cx) == cw - 1'b1) begin
            cx <= '0;
            cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            cur <= q_data;
            res.read_colour       <= '0;
            res.pixels_written    <= '0;
            res.pixels_skipped    <= '0;
            res.read_out_of_range <= 1'b0;
            case (q_data.req)
              REQ_CLEAR: begin
                if (eff_w == '0 || eff_h == '0) begin
                  res.valid <= 1'b1;
                end else begin
                  cw    <= eff_w;
                  ch    <= eff_h;
                  cx    <= '0;
                  cy    <= '0;
                  state <= B_CLR;
                end
              end
              REQ_LINE: begin
                cw      <= eff_w;
                ch      <= eff_h;
                fx      <= q_data.fx;
                rx      <= q_data.rx;
                fy      <= q_data.fy;
                ry      <= q_data.ry;
                k       <= '0;
                written <= '0;
                skipped <= '0;
                state   <= B_LINE;
              end
              REQ_READ: begin
                if (rd_oor) begin
                  res.valid             <= 1'b1;
                  res.read_out_of_range <= 1'b1;
                end else begin
                  state <= B_RDW;
                end
              end
              default: res.valid <= 1'b1;
            endcase
          end
        end
        B_LINE: begin
          ptx <= rnd(fx, rx, cur.den);
          pty <= rnd(fy, ry, cur.den);
          fx  <= nx.f;
          rx  <= nx.r;
          fy  <= ny.f;
          ry  <= ny.r;
          k   <= k + 1'b1;
          if (k == cur.d) begin
            state <= B_LEND;
          end
        end
        B_LEND: state <= B_LOUT;
        B_LOUT: begin
          res.valid          <= 1'b1;
          res.pixels_written <= written;
          res.pixels_skipped <= skipped;
          state              <= B_IDLE;
        end
        B_RDW: begin
          res.valid       <= 1'b1;
          res.read_colour <= rdata;
          state           <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_line_raster_framebuffer_top.sv]
// ----------------------------------------------------------------------------
// tb_line_raster_framebuffer_top
// Self-checking bench for the line raster framebuffer. A short table of
// directed words runs first, then random clear/line/read traffic under
// several register settings and idle/stall mixes. Each result word is checked
// against its row's hand-typed result if any, else an in-bench framebuffer model.
// ----------------------------------------------------------------------------
module tb_line_raster_framebuffer_top;
  import lrf_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;  // unused code, must be a no-op

  typedef struct {
    logic [1:0]         rt;
    logic signed [15:0] sx, sy, ex, ey;
    logic [23:0]        col;
    logic [7:0]         px, py;
  } cmd_s;

  typedef struct {
    logic [23:0] rc;
    logic [16:0] pw, ps;
    logic        oor;
  } res_s;

  // directed row: word plus an optional hand-typed result
  typedef struct {
    cmd_s c;
    bit   typed;
    res_s r;
  } row_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SCALE;
  logic [11:0] cfg_data = '0;

  lrf_req_if req ();
  lrf_res_if res ();

  line_raster_framebuffer_top u_top (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- framebuffer model ---------------------------------------------------
  logic [23:0] fb_img [0:65535];
  int unsigned m_scale = 256, m_width = 256, m_height = 256;

  res_s        res_q [$];   // expected result words, oldest first
  int          n_err = 0;
  int          n_checked = 0;
  int          n_line = 0, n_read = 0, n_clear = 0, n_other = 0;

  function automatic int unsigned eff_w();
    return (m_width > MAX_WIDTH) ? MAX_WIDTH : m_width;
  endfunction

  function automatic int unsigned eff_h();
    return (m_height > MAX_HEIGHT) ? MAX_HEIGHT : m_height;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // nearest, ties away from zero
  function automatic longint div_round(longint n, longint den);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + den / 2) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic void paint_clear();
    int unsigned w, h;
    w = eff_w();
    h = eff_h();
    if (w == 0 || h == 0) return;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) fb_img[y*256 + x] = PIX_WHITE;
    for (int x = 0; x < w; x++) begin
      fb_img[x] = PIX_BLACK;
      fb_img[(h-1)*256 + x] = PIX_BLACK;
    end
  endfunction

  // Applies one word to the model and returns the result word it yields.
  function automatic res_s raster_step(cmd_s c);
    res_s o;
    longint s, p0x, p0y, p1x, p1y, dx, dy, d, dd, den, k, x, y, w, h;
    longint unsigned sq;
    o = '{rc: '0, pw: '0, ps: '0, oor: 1'b0};
    case (c.rt)
      REQ_CLEAR: paint_clear();
      REQ_LINE: begin
        s = m_scale;
        p0x = longint'(c.sx) * s;  p0y = longint'(c.sy) * s;
        p1x = longint'(c.ex) * s;  p1y = longint'(c.ey) * s;
        dx = p0x - p1x;
        dy = p0y - p1y;
        sq = dx*dx + dy*dy;
        d = longint'(sqrt_floor(sq) / 4096);
        dd = (d == 0) ? 1 : d;
        den = dd * 4096;
        w = eff_w();
        h = eff_h();
        for (k = 0; k <= d; k++) begin
          x = div_round(p1x*dd + k*dx, den);
          y = div_round(p1y*dd + k*dy, den);
          if (x < 0 || x >= w || y < 0 || y >= h) begin
            o.ps++;
          end else begin
            fb_img[y*256 + x] = c.col;
            o.pw++;
          end
        end
      end
      REQ_READ: begin
        if (c.px >= eff_w() || c.py >= eff_h()) o.oor = 1'b1;
        else o.rc = fb_img[c.py*256 + c.px];
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---- driving -------------------------------------------------------------
  int unsigned idle_pct = 0;   // sender gap chance per cycle
  int unsigned stall_pct = 0;  // receiver stall chance per cycle
  logic hold = 1'b0;           // long receiver hold-off
  logic hold_go = 1'b0;
  bit   pin_typed = 0;         // hand-typed result rides along with the word
  res_s pin_res;

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_CLEAR;
    req.start_x = '0; req.start_y = '0; req.end_x = '0; req.end_y = '0;
    req.colour = '0; req.pixel_x = '0; req.pixel_y = '0;
    res.ready = 1'b0;
    pin_res = '{rc: '0, pw: '0, ps: '0, oor: 1'b0};
  end

  always @(posedge clk) begin
    res.ready <= !hold && ($urandom_range(99) >= stall_pct);
  end

  // hold-off runs in its own process, counted in cycles
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (600) @(posedge clk);
    hold <= 1'b0;
  end

  task automatic send_word(cmd_s c, bit typed, res_s r);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= c.rt;
    req.start_x <= c.sx;  req.start_y <= c.sy;
    req.end_x <= c.ex;    req.end_y <= c.ey;
    req.colour <= c.col;
    req.pixel_x <= c.px;  req.pixel_y <= c.py;
    pin_typed <= typed;
    pin_res <= r;
    do @(posedge clk); while (!req.ready);
    case (c.rt)
      REQ_CLEAR: n_clear++;
      REQ_LINE:  n_line++;
      REQ_READ:  n_read++;
      default:   n_other++;
    endcase
  endtask

  // all three registers on back-to-back edges, enable held high throughout
  task automatic write_regs(int unsigned s, int unsigned w, int unsigned h);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_SCALE; cfg_data <= s[11:0];
    @(posedge clk);
    cfg_index <= CFG_WIDTH; cfg_data <= w[11:0];
    @(posedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= h[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    m_scale = s & 12'hFFF;
    m_width = w & 9'h1FF;
    m_height = h & 9'h1FF;
  endtask

  task automatic drain();
    while (res_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---- monitors ------------------------------------------------------------
  always @(posedge clk) begin
    res_s e;
    cmd_s c;
    if (!rst && req.valid && req.ready) begin
      c.rt = req.req_type;
      c.sx = req.start_x;  c.sy = req.start_y;
      c.ex = req.end_x;    c.ey = req.end_y;
      c.col = req.colour;
      c.px = req.pixel_x;  c.py = req.pixel_y;
      e = raster_step(c);
      res_q.push_back(pin_typed ? pin_res : e);
    end
    if (!rst && res.valid && res.ready) begin
      if (res_q.size() == 0) begin
        $error("result word with nothing expected");
        n_err++;
      end else begin
        e = res_q.pop_front();
        n_checked++;
        if (res.read_colour !== e.rc) begin
          $error("read_colour exp %h got %h", e.rc, res.read_colour); n_err++;
        end
        if (res.pixels_written !== e.pw) begin
          $error("pixels_written exp %0d got %0d", e.pw, res.pixels_written); n_err++;
        end
        if (res.pixels_skipped !== e.ps) begin
          $error("pixels_skipped exp %0d got %0d", e.ps, res.pixels_skipped); n_err++;
        end
        if (res.read_out_of_range !== e.oor) begin
          $error("read_out_of_range exp %b got %b", e.oor, res.read_out_of_range);
          n_err++;
        end
      end
    end
  end

  // ---- random words --------------------------------------------------------
  // world coordinate that lands near a given pixel under the current scale
  function automatic logic signed [15:0] to_world(int pix);
    longint v;
    if (m_scale == 0) return 16'($urandom);
    v = (longint'(pix) * 4096) / longint'(m_scale) + $signed($urandom_range(16)) - 8;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic cmd_s rand_word();
    cmd_s c;
    int unsigned pick;
    int x0, y0;
    c.rt = REQ_LINE;
    c.sx = 16'($urandom); c.sy = 16'($urandom);
    c.ex = 16'($urandom); c.ey = 16'($urandom);
    c.col = 24'($urandom);
    c.px = 8'($urandom);  c.py = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      // short line around the image; some ends fall outside
      x0 = $signed($urandom_range(290)) - 16;
      y0 = $signed($urandom_range(290)) - 16;
      c.sx = to_world(x0);
      c.sy = to_world(y0);
      c.ex = to_world(x0 + $signed($urandom_range(80)) - 40);
      c.ey = to_world(y0 + $signed($urandom_range(80)) - 40);
      if ($urandom_range(9) == 0) begin
        c.ex = c.sx;
        c.ey = c.sy;
      end
    end else if (pick < 62) begin
      // raw endpoints, kept short at large scales
      if (m_scale > 300) begin
        c.sx = 16'($signed(c.sx) >>> 5); c.sy = 16'($signed(c.sy) >>> 5);
        c.ex = 16'($signed(c.ex) >>> 5); c.ey = 16'($signed(c.ey) >>> 5);
      end
    end else if (pick < 92) begin
      c.rt = REQ_READ;
      if ($urandom_range(1) == 0 && eff_w() != 0 && eff_h() != 0) begin
        c.px = 8'($urandom_range(eff_w() - 1));
        c.py = 8'($urandom_range(eff_h() - 1));
      end
    end else if (pick < 96) begin
      // full-size clears are slow, keep them to small images
      c.rt = (eff_w() * eff_h() <= 4096) ? REQ_CLEAR : REQ_READ;
    end else begin
      c.rt = REQ_BAD;
    end
    return c;
  endfunction

  // ---- directed table ------------------------------------------------------
  function automatic row_s mk(logic [1:0] rt, int sx, int sy, int ex, int ey,
                              int col, int px, int py, bit typed,
                              int rc, int pw, int ps, bit oor);
    row_s r;
    r.c = '{rt: rt, sx: 16'(sx), sy: 16'(sy), ex: 16'(ex), ey: 16'(ey),
            col: 24'(col), px: 8'(px), py: 8'(py)};
    r.typed = typed;
    r.r = '{rc: 24'(rc), pw: 17'(pw), ps: 17'(ps), oor: oor};
    return r;
  endfunction

  row_s rows [$];

  initial begin
    // after reset: black frame rows, white inside
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,   0,   0, 1, 24'h000000, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,   5,   5, 1, 24'hFFFFFF, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,   7, 255, 1, 24'h000000, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0, 255, 128, 1, 24'hFFFFFF, 0, 0, 0));
    // zero-length line: one point at the second endpoint
    rows.push_back(mk(REQ_LINE, 256, 256, 256, 256, 24'h123456, 0, 0, 1, 0, 1, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,  16,  16, 1, 24'h123456, 0, 0, 0));
    // horizontal run of ten pixels on row 10
    rows.push_back(mk(REQ_LINE, 144, 160, 0, 160, 24'hABCDEF, 0, 0, 1, 0, 10, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,   4,  10, 1, 24'hABCDEF, 0, 0, 0));
    // entirely off image
    rows.push_back(mk(REQ_LINE, -320, -320, -320, -160, 24'h00FF00, 0, 0, 1, 0, 0, 11, 0));
    // extreme endpoints both ways
    rows.push_back(mk(REQ_LINE, 32767, 32767, -32768, -32768, 24'hFFFFFF, 0, 0,
                      0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_LINE, -32768, 32767, 32767, -32768, 24'h000001, 0, 0,
                      0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_LINE, 0, 32767, 4000, 8, 24'h800000, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0, 255, 255, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0, 128, 128, 0, 0, 0, 0, 0));
    // unused request code: all-zero result
    rows.push_back(mk(REQ_BAD, 100, 100, -100, -100, 24'hFFFFFF, 255, 255,
                      1, 0, 0, 0, 0));
    rows.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 24'h555555, 0, 0, 1, 0, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,   3,   3, 1, 24'hFFFFFF, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,  16,  16, 1, 24'hFFFFFF, 0, 0, 0));
    rows.push_back(mk(REQ_READ,  0, 0, 0, 0, 0,  16, 255, 1, 24'h000000, 0, 0, 0));
  end

  // ---- main sequence -------------------------------------------------------
  // Phase settings: scale, width, height. Covers the extremes, sizes above the
  // maximum, zero width, scale zero and a one-row image.
  int unsigned ph_scale  [6] = '{256, 4095,   1,   0, 700,  256};
  int unsigned ph_width  [6] = '{256,  511,  17,   0, 100,  256};
  int unsigned ph_height [6] = '{256,  300,   9,  40, 200,    1};
  int unsigned ph_idle   [4] = '{0, 45,  0, 28};
  int unsigned ph_stall  [4] = '{0,  0, 45, 28};

  initial begin
    cmd_s c;
    res_s none;
    none = '{rc: '0, pw: '0, ps: '0, oor: 1'b0};
    for (int i = 0; i < 65536; i++) fb_img[i] = PIX_WHITE;
    paint_clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // registers may be written during the reset sweep; reset values here
    write_regs(256, 256, 256);
    foreach (rows[i]) send_word(rows[i].c, rows[i].typed, rows[i].r);
    req.valid <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      write_regs(ph_scale[p], ph_width[p], ph_height[p]);
      idle_pct = ph_idle[p % 4];
      stall_pct = ph_stall[p % 4];
      if (p == 2) hold_go <= 1'b1;  // receiver blocks while words keep coming
      // one full-range line per setting, longest at the top scale
      c = rand_word();
      c.rt = REQ_LINE;
      c.sx = 16'sh7FFF; c.sy = 16'sh7FFF; c.ex = -16'sh8000; c.ey = -16'sh8000;
      send_word(c, 0, none);
      for (int n = 0; n < 80; n++) send_word(rand_word(), 0, none);
      req.valid <= 1'b0;
      drain();
    end

    $display("covered %0d lines, %0d reads, %0d clears, %0d unused codes",
             n_line, n_read, n_clear, n_other);
    $display("%0d result words checked over 6 register settings", n_checked);
    if (n_err == 0 && res_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (res_q.size() != 0) $error("%0d results never arrived", res_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: far above reset sweep, one 92k-point line and all traffic
  initial begin
    #(8 * 6_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
